@@ hw/rtl/rational_add_sub_reduce_core_assert.svh @@
// Assertion macros for the rational add/sub/reduce core checker.
// No dependencies; included by the checker file only.
`ifndef RATIONAL_ADD_SUB_REDUCE_CORE_ASSERT_SVH
`define RATIONAL_ADD_SUB_REDUCE_CORE_ASSERT_SVH

// Clocked assertion, masked while reset is active.
`define RSR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that is also checked during reset.
`define RSR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ hw/rtl/rsr_pkg.sv @@
// Shared constants and operation codes for the rational add/sub/reduce core.
// No dependencies.
`default_nettype none

package rsr_pkg;

  // Width of every fraction part on the ports.
  localparam int unsigned DATA_WIDTH = 32;
  // Width of exact intermediates (products of two parts).
  localparam int unsigned WIDE_WIDTH = 2 * DATA_WIDTH;

  // Operation codes carried by the func field.
  typedef enum logic [1:0] {
    FUNC_NORM = 2'd0,
    FUNC_ADD  = 2'd1,
    FUNC_SUB  = 2'd2,
    FUNC_EQ   = 2'd3
  } func_e;

endpackage

`default_nettype wire

@@ hw/rtl/rsr_req_if.sv @@
// Request and response channel interfaces for the rational core.
// Depends on rsr_pkg for the data width.
`default_nettype none

interface rsr_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            func;
  logic signed [rsr_pkg::DATA_WIDTH-1:0] left_num;
  logic signed [rsr_pkg::DATA_WIDTH-1:0] left_den;
  logic signed [rsr_pkg::DATA_WIDTH-1:0] right_num;
  logic signed [rsr_pkg::DATA_WIDTH-1:0] right_den;

  modport source (output valid, func, left_num, left_den, right_num, right_den,
                  input ready);
  modport sink   (input valid, func, left_num, left_den, right_num, right_den,
                  output ready);
endinterface

interface rsr_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rsr_pkg::DATA_WIDTH-1:0] result_num;
  logic signed [rsr_pkg::DATA_WIDTH-1:0] result_den;
  logic                                  is_equal;
  logic                                  overflow;

  modport source (output valid, result_num, result_den, is_equal, overflow,
                  input ready);
  modport sink   (input valid, result_num, result_den, is_equal, overflow,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rational_add_sub_reduce_core.sv @@
// Rational add/subtract/normalize/compare core with gcd reduction.
// Depends on rsr_pkg and the rsr_req_if / rsr_rsp_if interfaces.
//
//  channel | dir | handshake      | payload
//  req_i   | in  | valid / ready  | func, left_num, left_den, right_num, right_den
//  rsp_o   | out | valid / ready  | result_num, result_den, is_equal, overflow
//
// One request is worked at a time; req_i.ready is high only when the sequencer idles.
// A request runs one to three reductions, each a binary gcd plus two restoring
// divides (numerator, then denominator) on the shared gcd/divide datapath.
// Cross products use one shared 32x32 multiplier, one product per cycle.
// Reset clears the sequencer and the response valid; a stalled response is held in
// its output register while the next request is already taken.
`default_nettype none

module rational_add_sub_reduce_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsr_req_if.sink     req_i,
  rsr_rsp_if.source   rsp_o
);

  localparam int unsigned W  = rsr_pkg::DATA_WIDTH;
  localparam int unsigned WW = rsr_pkg::WIDE_WIDTH;
  localparam int unsigned CW = $clog2(WW);
  localparam logic [WW-1:0] HALF = WW'(1) << (W - 1);
  localparam logic [WW-1:0] MAXP = HALF - WW'(1);

  typedef struct packed {
    logic         neg;
    logic [W-1:0] mag;
    logic [W-1:0] den;
  } frac_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RED_START, S_RED_TWO, S_RED_AEVEN, S_RED_LOOP, S_RED_SCALE,
    S_DIV_X, S_DIV_Y, S_RED_DONE, S_MUL_A, S_MUL_B, S_MUL_D, S_SUM, S_EMIT
  } state_e;

  typedef enum logic [1:0] {PH_A, PH_B, PH_R} phase_e;

  // Sign-fix a fraction so the denominator is non-negative, split sign and magnitude.
  function automatic frac_t load_op(input logic [W-1:0] n, input logic [W-1:0] d);
    logic [W:0] ne, de, nf, df, nm;
    frac_t      f;
    ne = {n[W-1], n};
    de = {d[W-1], d};
    nf = d[W-1] ? (~ne + (W+1)'(1)) : ne;
    df = d[W-1] ? (~de + (W+1)'(1)) : de;
    nm = nf[W] ? (~nf + (W+1)'(1)) : nf;
    f.neg = nf[W];
    f.mag = nm[W-1:0];
    f.den = df[W-1:0];
    return f;
  endfunction

  state_e              state_q;
  phase_e              phase_q;
  rsr_pkg::func_e      func_q;
  logic                a_neg_q, b_neg_q, r_neg_q, eq_q;
  logic [W-1:0]        a_mag_q, a_den_q, b_mag_q, b_den_q;
  logic [WW-1:0]       am_q, bm_q, rden_q;
  logic [WW-1:0]       x_q, y_q, ga_q, gb_q, rem_q, quo_q;
  logic [CW-1:0]       k_q, cnt_q;
  logic                rsp_valid_q, eq_out_q, ovf_q;
  logic [W-1:0]        num_out_q, den_out_q;

  frac_t               fa, fb;
  logic [W-1:0]        mul_a, mul_b;
  logic [WW-1:0]       prod;
  logic [WW:0]         trial;
  logic                div_ge;
  logic [WW-1:0]       rem_n, quo_n;
  logic                red_neg, sum_ge;
  logic [WW-1:0]       sum_mag;
  logic [W-1:0]        emit_num, emit_den;
  logic                emit_ovf;
  logic                div_last;

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.result_num = num_out_q;
  assign rsp_o.result_den = den_out_q;
  assign rsp_o.is_equal   = eq_out_q;
  assign rsp_o.overflow   = ovf_q;

  // Sign-fix both operands as they arrive
  assign fa = load_op(req_i.left_num, req_i.left_den);
  assign fb = load_op(req_i.right_num, req_i.right_den);

  // Select operands of the shared multiplier
  always_comb begin
    mul_a = a_den_q;
    mul_b = b_den_q;
    case (state_q)
      S_MUL_A: begin
        mul_a = a_mag_q;
        mul_b = b_den_q;
      end
      S_MUL_B: begin
        mul_a = b_mag_q;
        mul_b = a_den_q;
      end
      default: begin
        mul_a = a_den_q;
        mul_b = b_den_q;
      end
    endcase
  end
  assign prod = WW'(mul_a) * WW'(mul_b);

  // One restoring divide step: remainder against the gcd
  assign trial  = {rem_q, quo_q[WW-1]};
  assign div_ge = (trial >= {1'b0, ga_q});
  always_comb begin
    if (div_ge) begin
      rem_n = WW'(trial - {1'b0, ga_q});
    end else begin
      rem_n = trial[WW-1:0];
    end
  end
  assign quo_n    = {quo_q[WW-2:0], div_ge};
  assign div_last = (cnt_q == CW'(WW - 1));

  // Zero numerator always ends up positive
  assign red_neg = r_neg_q & (|x_q);

  // Signed add of the scaled magnitudes
  assign sum_ge = (am_q >= bm_q);
  always_comb begin
    if (a_neg_q == b_neg_q) begin
      sum_mag = am_q + bm_q;
    end else if (sum_ge) begin
      sum_mag = am_q - bm_q;
    end else begin
      sum_mag = bm_q - am_q;
    end
  end

  // Saturate the reduced result to the port width
  always_comb begin
    emit_ovf = 1'b0;
    if (r_neg_q) begin
      if (x_q > HALF) begin
        emit_num = W'(0) - HALF[W-1:0];
        emit_ovf = 1'b1;
      end else begin
        emit_num = W'(0) - x_q[W-1:0];
      end
    end else begin
      if (x_q > MAXP) begin
        emit_num = MAXP[W-1:0];
        emit_ovf = 1'b1;
      end else begin
        emit_num = x_q[W-1:0];
      end
    end
    if (y_q > MAXP) begin
      emit_den = MAXP[W-1:0];
      emit_ovf = 1'b1;
    end else begin
      emit_den = y_q[W-1:0];
    end
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_A;
      rsp_valid_q <= 1'b0;
    end else begin
      // drop the response once taken, unless a new one is loaded now
      if (rsp_valid_q && rsp_o.ready && (state_q != S_EMIT)) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            func_q  <= rsr_pkg::func_e'(req_i.func);
            a_neg_q <= fa.neg;
            a_mag_q <= fa.mag;
            a_den_q <= fa.den;
            b_neg_q <= fb.neg;
            b_mag_q <= fb.mag;
            b_den_q <= fb.den;
            r_neg_q <= fa.neg;
            x_q     <= WW'(fa.mag);
            y_q     <= WW'(fa.den);
            ga_q    <= WW'(fa.mag);
            gb_q    <= WW'(fa.den);
            phase_q <= PH_A;
            state_q <= S_RED_START;
          end
        end
        // handle zero operands, else begin the binary gcd
        S_RED_START: begin
          k_q   <= '0;
          rem_q <= '0;
          quo_q <= x_q;
          cnt_q <= '0;
          if (ga_q == '0 && gb_q == '0) begin
            ga_q    <= WW'(1);
            state_q <= S_DIV_X;
          end else if (ga_q == '0) begin
            ga_q    <= gb_q;
            state_q <= S_DIV_X;
          end else if (gb_q == '0) begin
            state_q <= S_DIV_X;
          end else begin
            state_q <= S_RED_TWO;
          end
        end
        // strip common factors of two
        S_RED_TWO: begin
          if (ga_q[0] || gb_q[0]) begin
            state_q <= S_RED_AEVEN;
          end else begin
            ga_q <= ga_q >> 1;
            gb_q <= gb_q >> 1;
            k_q  <= k_q + CW'(1);
          end
        end
        S_RED_AEVEN: begin
          if (ga_q[0]) begin
            state_q <= S_RED_LOOP;
          end else begin
            ga_q <= ga_q >> 1;
          end
        end
        // odd-odd subtract loop
        S_RED_LOOP: begin
          if (gb_q == '0) begin
            state_q <= S_RED_SCALE;
          end else if (!gb_q[0]) begin
            gb_q <= gb_q >> 1;
          end else if (ga_q > gb_q) begin
            ga_q <= gb_q;
            gb_q <= ga_q;
          end else begin
            gb_q <= gb_q - ga_q;
          end
        end
        // restore the common power of two
        S_RED_SCALE: begin
          if (k_q == '0) begin
            rem_q   <= '0;
            quo_q   <= x_q;
            cnt_q   <= '0;
            state_q <= S_DIV_X;
          end else begin
            ga_q <= ga_q << 1;
            k_q  <= k_q - CW'(1);
          end
        end
        S_DIV_X: begin
          cnt_q <= cnt_q + CW'(1);
          if (div_last) begin
            x_q     <= quo_n;
            rem_q   <= '0;
            quo_q   <= y_q;
            state_q <= S_DIV_Y;
          end else begin
            rem_q <= rem_n;
            quo_q <= quo_n;
          end
        end
        S_DIV_Y: begin
          rem_q <= rem_n;
          quo_q <= quo_n;
          cnt_q <= cnt_q + CW'(1);
          if (div_last) begin
            y_q     <= quo_n;
            state_q <= S_RED_DONE;
          end
        end
        // dispatch on which reduction just finished
        S_RED_DONE: begin
          case (phase_q)
            PH_A: begin
              a_neg_q <= red_neg;
              a_mag_q <= x_q[W-1:0];
              a_den_q <= y_q[W-1:0];
              if (func_q == rsr_pkg::FUNC_NORM) begin
                r_neg_q <= red_neg;
                state_q <= S_EMIT;
              end else begin
                r_neg_q <= b_neg_q;
                x_q     <= WW'(b_mag_q);
                y_q     <= WW'(b_den_q);
                ga_q    <= WW'(b_mag_q);
                gb_q    <= WW'(b_den_q);
                phase_q <= PH_B;
                state_q <= S_RED_START;
              end
            end
            PH_B: begin
              b_mag_q <= x_q[W-1:0];
              b_den_q <= y_q[W-1:0];
              b_neg_q <= red_neg ^ ((func_q == rsr_pkg::FUNC_SUB) & (|x_q));
              eq_q    <= (a_neg_q == red_neg) && (WW'(a_mag_q) == x_q) &&
                         (WW'(a_den_q) == y_q);
              if (func_q == rsr_pkg::FUNC_EQ) begin
                state_q <= S_EMIT;
              end else if (WW'(a_den_q) != y_q) begin
                state_q <= S_MUL_A;
              end else begin
                am_q    <= WW'(a_mag_q);
                bm_q    <= x_q;
                rden_q  <= y_q;
                state_q <= S_SUM;
              end
            end
            default: begin
              r_neg_q <= red_neg;
              state_q <= S_EMIT;
            end
          endcase
        end
        S_MUL_A: begin
          am_q    <= prod;
          state_q <= S_MUL_B;
        end
        S_MUL_B: begin
          bm_q    <= prod;
          state_q <= S_MUL_D;
        end
        S_MUL_D: begin
          rden_q  <= prod;
          state_q <= S_SUM;
        end
        // combine signs and start the final reduction
        S_SUM: begin
          r_neg_q <= ((a_neg_q == b_neg_q) || sum_ge) ? a_neg_q : b_neg_q;
          x_q     <= sum_mag;
          y_q     <= rden_q;
          ga_q    <= sum_mag;
          gb_q    <= rden_q;
          phase_q <= PH_R;
          state_q <= S_RED_START;
        end
        // load the output register when it is free
        S_EMIT: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q <= 1'b1;
            if (func_q == rsr_pkg::FUNC_EQ) begin
              num_out_q <= '0;
              den_out_q <= '0;
              eq_out_q  <= eq_q;
              ovf_q     <= 1'b0;
            end else begin
              num_out_q <= emit_num;
              den_out_q <= emit_den;
              eq_out_q  <= 1'b0;
              ovf_q     <= emit_ovf;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rsr_core_chk.sv @@
// Port-level checker for the rational core, bound to the top level.
// Depends on rsr_pkg and the assertion macro header.
`default_nettype none
`include "rational_add_sub_reduce_core_assert.svh"

module rsr_core_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [rsr_pkg::DATA_WIDTH-1:0] result_num_i,
  input logic [rsr_pkg::DATA_WIDTH-1:0] result_den_i,
  input logic                           is_equal_i,
  input logic                           overflow_i
);

  // No response may be pending right after a reset edge
  `RSR_ASSERT_ALWAYS(a_rsp_clear_rst, clk_i, !rst_ni |=> !rsp_valid_i, "rsp valid after reset")

  // A taken request keeps the core busy next cycle
  `RSR_ASSERT(a_busy_after_req, clk_i, rst_ni,
    req_valid_i && req_ready_i |=> !req_ready_i, "ready after request")

  // Reduced denominator is never negative
  `RSR_ASSERT(a_den_nonneg, clk_i, rst_ni,
    rsp_valid_i |-> !result_den_i[rsr_pkg::DATA_WIDTH-1], "negative denominator")

  // Responses that report equality carry no fraction and no overflow
  `RSR_ASSERT(a_eq_clean, clk_i, rst_ni,
    rsp_valid_i && is_equal_i |-> result_num_i == '0 && result_den_i == '0 && !overflow_i,
    "dirty compare response")

  // A stalled response holds
  `RSR_ASSERT(a_rsp_hold, clk_i, rst_ni,
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(result_num_i) && $stable(result_den_i),
    "stalled response changed")

endmodule

bind rational_add_sub_reduce_core rsr_core_chk u_rsr_core_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .result_num_i (rsp_o.result_num),
  .result_den_i (rsp_o.result_den),
  .is_equal_i   (rsp_o.is_equal),
  .overflow_i   (rsp_o.overflow)
);

`default_nettype wire

@@ bench/rsr_bench_if.sv @@
// Spare file slot for the bench; the channel interfaces come from the RTL tree.
// No dependencies.
`timescale 1ns / 1ps

package rsr_bench_pkg;
  // Longest idle stretch, in cycles, for the receiver hold-off.
  localparam int unsigned HOLD_OFF_CYCLES = 4000;
endpackage

@@ bench/rational_add_sub_reduce_core_tb.sv @@
// Self-checking bench for rational_add_sub_reduce_core: table-driven directed
// requests, then random requests checked against an exact fraction predictor.
// Depends on rsr_pkg, rsr_req_if, rsr_rsp_if and rsr_bench_pkg.
`timescale 1ns / 1ps

module rational_add_sub_reduce_core_tb;

  localparam int unsigned DW        = rsr_pkg::DATA_WIDTH;
  localparam int unsigned N_RANDOM  = 1930;
  localparam int unsigned WDOG_MAX  = 200000;

  typedef logic signed [DW-1:0] word_t;

  typedef struct packed {
    rsr_pkg::func_e func;
    word_t ln, ld, rn, rd;
  } req_t;

  typedef struct packed {
    word_t num, den;
    logic  eq, ovf;
  } rsp_t;

  typedef struct {
    logic        neg;
    logic [63:0] mag;
    logic [63:0] den;
  } frac_t;

  typedef struct {
    req_t rq;
    logic has_exp;
    rsp_t exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors = 0;
  int   idle_cycles = 0;
  logic send_done = 1'b0;
  logic hold_off = 1'b0;
  rsp_t expected_q[$];

  rsr_req_if req_if();
  rsr_rsp_if rsp_if();

  rational_add_sub_reduce_core u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  always #5 clk_i = ~clk_i;

  // Binary gcd on magnitudes, with the zero conventions of the block.
  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    int k;
    logic [63:0] t;
    k = 0;
    if (a == 0 && b == 0) return 64'd1;
    if (a == 0) return b;
    if (b == 0) return a;
    while (((a | b) & 1) == 0) begin
      a >>= 1; b >>= 1; k++;
    end
    while ((a & 1) == 0) a >>= 1;
    while (b != 0) begin
      while ((b & 1) == 0) b >>= 1;
      if (a > b) begin
        t = a; a = b; b = t;
      end
      b -= a;
    end
    return a << k;
  endfunction

  function automatic frac_t lowest_terms(frac_t f);
    logic [63:0] g;
    g = gcd64(f.mag, f.den);
    f.mag /= g;
    f.den /= g;
    if (f.mag == 0) f.neg = 1'b0;
    return f;
  endfunction

  // Move the sign to the numerator and reduce.
  function automatic frac_t load_frac(word_t n, word_t d);
    logic signed [63:0] sn, sd;
    frac_t f;
    sn = n;
    sd = d;
    if (sd < 0) begin
      sn = -sn; sd = -sd;
    end
    f.neg = sn < 0;
    f.mag = sn < 0 ? -sn : sn;
    f.den = sd;
    return lowest_terms(f);
  endfunction

  function automatic frac_t sum_frac(frac_t a, frac_t b);
    frac_t r;
    logic [63:0] am, bm;
    am = a.mag;
    bm = b.mag;
    r.den = a.den;
    if (a.den != b.den) begin
      am = a.mag * b.den;
      bm = b.mag * a.den;
      r.den = a.den * b.den;
    end
    if (a.neg == b.neg) begin
      r.neg = a.neg; r.mag = am + bm;
    end else if (am >= bm) begin
      r.neg = a.neg; r.mag = am - bm;
    end else begin
      r.neg = b.neg; r.mag = bm - am;
    end
    return lowest_terms(r);
  endfunction

  // Saturate to the port width.
  function automatic rsp_t pack_frac(frac_t f);
    rsp_t r;
    logic [63:0] half;
    half = 64'd1 << (DW - 1);
    r.ovf = 1'b0;
    r.eq = 1'b0;
    if (f.neg) begin
      if (f.mag > half) begin
        f.mag = half; r.ovf = 1'b1;
      end
      r.num = word_t'(-f.mag);
    end else begin
      if (f.mag > half - 1) begin
        f.mag = half - 1; r.ovf = 1'b1;
      end
      r.num = word_t'(f.mag);
    end
    if (f.den > half - 1) begin
      f.den = half - 1; r.ovf = 1'b1;
    end
    r.den = word_t'(f.den);
    return r;
  endfunction

  function automatic rsp_t predict_fraction(req_t q);
    frac_t a, b;
    rsp_t r;
    a = load_frac(q.ln, q.ld);
    b = load_frac(q.rn, q.rd);
    r = '0;
    case (q.func)
      rsr_pkg::FUNC_NORM: r = pack_frac(a);
      rsr_pkg::FUNC_ADD:  r = pack_frac(sum_frac(a, b));
      rsr_pkg::FUNC_SUB: begin
        if (b.mag != 0) b.neg = ~b.neg;
        r = pack_frac(sum_frac(a, b));
      end
      default: r.eq = (a.neg == b.neg && a.mag == b.mag && a.den == b.den);
    endcase
    return r;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom_range(0, 12)) - 6;
      1: return word_t'($urandom_range(1, 1000)) * ($urandom_range(0, 1) ? 1 : -1);
      2: return {1'b1, {(DW-1){1'b0}}} + word_t'($urandom_range(0, 3));
      3: return {1'b0, {(DW-1){1'b1}}} - word_t'($urandom_range(0, 3));
      4: return word_t'($urandom_range(1, 64)) << $urandom_range(0, 24);
      default: return word_t'($urandom);
    endcase
  endfunction

  // Send one request after a random gap; wait for the handshake.
  task automatic send_request(req_t q, logic has_exp, rsp_t exp);
    rsp_t p;
    int unsigned gap;
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.func <= q.func;
    req_if.left_num <= q.ln;
    req_if.left_den <= q.ld;
    req_if.right_num <= q.rn;
    req_if.right_den <= q.rd;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    p = predict_fraction(q);
    if (has_exp && p != exp) begin
      $error("table row disagrees with predictor: exp %h pred %h", exp, p);
      errors++;
    end
    expected_q.push_back(has_exp ? exp : p);
    @(negedge clk_i);
  endtask

  localparam word_t WMIN = {1'b1, {(DW-1){1'b0}}};
  localparam word_t WMAX = {1'b0, {(DW-1){1'b1}}};

  row_t directed[$];

  function automatic row_t mk(rsr_pkg::func_e f, word_t a, word_t b, word_t c, word_t d,
                              logic he, word_t en, word_t ed, logic eq, logic ov);
    row_t r;
    r.rq = '{f, a, b, c, d};
    r.has_exp = he;
    r.exp = '{en, ed, eq, ov};
    return r;
  endfunction

  // Stimulus.
  initial begin
    req_t q;
    rsp_t z;
    z = '0;
    req_if.valid = 1'b0;
    req_if.func = rsr_pkg::FUNC_NORM;
    req_if.left_num = '0;
    req_if.left_den = '0;
    req_if.right_num = '0;
    req_if.right_den = '0;
    directed.push_back(mk(rsr_pkg::FUNC_NORM, 6, 4, 0, 0, 1, 3, 2, 0, 0));
    directed.push_back(mk(rsr_pkg::FUNC_NORM, 3, -6, 0, 0, 1, -1, 2, 0, 0));
    directed.push_back(mk(rsr_pkg::FUNC_NORM, 0, -5, 0, 0, 1, 0, 1, 0, 0));
    directed.push_back(mk(rsr_pkg::FUNC_NORM, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    directed.push_back(mk(rsr_pkg::FUNC_NORM, -7, 0, 0, 0, 1, -1, 0, 0, 0));
    directed.push_back(mk(rsr_pkg::FUNC_NORM, 1, WMIN, 0, 0, 1, -1, WMAX, 0, 1));
    directed.push_back(mk(rsr_pkg::FUNC_NORM, WMIN, -1, 0, 0, 1, WMAX, 1, 0, 1));
    directed.push_back(mk(rsr_pkg::FUNC_NORM, WMIN, 1, 0, 0, 1, WMIN, 1, 0, 0));
    directed.push_back(mk(rsr_pkg::FUNC_NORM, WMAX, WMAX, 0, 0, 1, 1, 1, 0, 0));
    directed.push_back(mk(rsr_pkg::FUNC_ADD, 1, 2, 1, 3, 1, 5, 6, 0, 0));
    directed.push_back(mk(rsr_pkg::FUNC_ADD, 1, 4, 1, 4, 1, 1, 2, 0, 0));
    directed.push_back(mk(rsr_pkg::FUNC_SUB, 1, 2, 1, 2, 1, 0, 1, 0, 0));
    directed.push_back(mk(rsr_pkg::FUNC_SUB, 1, 3, 1, 2, 1, -1, 6, 0, 0));
    directed.push_back(mk(rsr_pkg::FUNC_ADD, WMAX, 1, WMAX, 1, 1, WMAX, 1, 0, 1));
    directed.push_back(mk(rsr_pkg::FUNC_SUB, WMIN, 1, WMAX, 1, 1, WMIN, 1, 0, 1));
    directed.push_back(mk(rsr_pkg::FUNC_ADD, 1, WMAX, 1, WMAX - 1, 0, 0, 0, 0, 0));
    directed.push_back(mk(rsr_pkg::FUNC_ADD, 1, 0, 1, 0, 1, 1, 0, 0, 0));
    directed.push_back(mk(rsr_pkg::FUNC_ADD, 0, 0, 3, 4, 0, 0, 0, 0, 0));
    directed.push_back(mk(rsr_pkg::FUNC_EQ, 2, 4, -1, -2, 1, 0, 0, 1, 0));
    directed.push_back(mk(rsr_pkg::FUNC_EQ, 1, 2, 1, 3, 1, 0, 0, 0, 0));
    directed.push_back(mk(rsr_pkg::FUNC_EQ, 0, 5, 0, -3, 1, 0, 0, 1, 0));
    directed.push_back(mk(rsr_pkg::FUNC_EQ, 0, 0, 0, 0, 1, 0, 0, 1, 0));
    directed.push_back(mk(rsr_pkg::FUNC_EQ, WMIN, WMIN, -1, -1, 1, 0, 0, 1, 0));
    directed.push_back(mk(rsr_pkg::FUNC_SUB, -1, -1, WMIN, WMAX, 0, 0, 0, 0, 0));
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[i]) send_request(directed[i].rq, directed[i].has_exp, directed[i].exp);
    for (int n = 0; n < N_RANDOM; n++) begin
      q.func = rsr_pkg::func_e'(2'($urandom_range(0, 3)));
      q.ln = rand_word();
      q.ld = rand_word();
      q.rn = rand_word();
      q.rd = rand_word();
      // Make equality hits common: a copy of the left fraction, both parts maybe negated.
      if (q.func == rsr_pkg::FUNC_EQ && $urandom_range(0, 1)) begin
        q.rn = q.ln * ($urandom_range(0, 1) ? 1 : -1);
        q.rd = q.ld * ($urandom_range(0, 1) ? 1 : -1);
        if ((q.rn == -q.ln) != (q.rd == -q.ld)) q.rn = -q.rn;
      end
      send_request(q, 1'b0, z);
    end
    req_if.valid <= 1'b0;
    send_done <= 1'b1;
  end

  // Receiver: random stalls, one long hold-off early on.
  initial begin
    int unsigned stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall = $urandom_range(0, 7);
        if (stall != 0) begin
          rsp_if.ready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Hold off the response side once, long enough to back up the input.
  initial begin
    @(posedge rst_ni);
    repeat (40000) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (rsr_bench_pkg::HOLD_OFF_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Compare each response with the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (rsp_if.result_num !== e.num) begin
          $error("result_num exp %0d got %0d", e.num, rsp_if.result_num); errors++;
        end
        if (rsp_if.result_den !== e.den) begin
          $error("result_den exp %0d got %0d", e.den, rsp_if.result_den); errors++;
        end
        if (rsp_if.is_equal !== e.eq) begin
          $error("is_equal exp %0b got %0b", e.eq, rsp_if.is_equal); errors++;
        end
        if (rsp_if.overflow !== e.ovf) begin
          $error("overflow exp %0b got %0b", e.ovf, rsp_if.overflow); errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake, and the end of run.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("rational_add_sub_reduce_core_tb: errors");
      $finish;
    end
  end

  initial begin
    wait (send_done);
    wait (expected_q.size() == 0);
    repeat (2000) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0)
      $display("rational_add_sub_reduce_core_tb: clean");
    else
      $display("rational_add_sub_reduce_core_tb: errors");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/rsr_pkg.sv
hw/rtl/rsr_req_if.sv
hw/rtl/rational_add_sub_reduce_core.sv
hw/rtl/rsr_core_chk.sv
bench/rsr_bench_if.sv
bench/rational_add_sub_reduce_core_tb.sv
